>>> hw/rtl/bb3_pkg.sv
`default_nettype none

package bb3_pkg;

    // Default for the widest frame the line store can hold.
    localparam int DEF_MAX_WIDTH = 1024;

    // Pixel and channel widths.
    localparam int CH_W  = 8;
    localparam int NCH   = 3;
    localparam int PIX_W = CH_W * NCH;

    // Rows kept in the line store, one RAM lane each.
    localparam int LANES  = 3;
    localparam int LANE_W = 2;

    // Configuration widths.
    localparam int CFG_DATA_W = 16;
    localparam int FW_W       = 11;
    localparam int ROW_W      = 16;

    // Neighbourhood sum and count widths.
    localparam int SUM_W = 12;
    localparam int CNT_W = 4;

    // Reciprocal constants for the rounded divide.
    localparam int RECIP_SH = 20;
    localparam int RECIP_W  = 20;
    localparam int X_W      = SUM_W + 1;
    localparam int PROD_W   = X_W + RECIP_W;

    // Command codes carried in tuser.
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    // Control carried with an output request from the issue stage to the sum stage.
    typedef struct packed {
        logic              top_ok;
        logic              bot_ok;
        logic              left_ok;
        logic              right_ok;
        logic [LANE_W-1:0] lane_top;
        logic [LANE_W-1:0] lane_mid;
        logic [LANE_W-1:0] lane_bot;
        logic              last;
        logic              fwd_a;
        logic              fwd_b;
        logic [LANE_W-1:0] fwd_lane;
        logic [PIX_W-1:0]  pix;
    } s1_ctrl_t;

    // Lane of the row above, modulo three.
    function automatic logic [LANE_W-1:0] lane_prev(input logic [LANE_W-1:0] l);
        logic [LANE_W-1:0] r;
        r = (l == 2'd0) ? 2'd2 : l - 2'd1;
        return r;
    endfunction

    // Lane of the row below, modulo three.
    function automatic logic [LANE_W-1:0] lane_next(input logic [LANE_W-1:0] l);
        logic [LANE_W-1:0] r;
        r = (l == 2'd2) ? 2'd0 : l + 2'd1;
        return r;
    endfunction

    // ceil(2^RECIP_SH / (2n)) for every neighbour count that can occur.
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] m;
        case (n)
            4'd1:    m = 20'd524288;
            4'd2:    m = 20'd262144;
            4'd3:    m = 20'd174763;
            4'd4:    m = 20'd131072;
            4'd6:    m = 20'd87382;
            4'd9:    m = 20'd58255;
            default: m = 20'd0;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/box_blur_3x3_stream_unit.sv
`default_nettype none

// Channel   | Direction | Handshake               | Payload
// s_*       | in        | s_tvalid / s_tready     | tdata blue, green, red; tuser cmd
// m_*       | out       | m_tvalid / m_tready     | tdata blue, green, red; tlast frame_end
// cfg_*     | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One request is accepted per clock while the output register is not stalled; a request that
// causes a result passes the RAM read, neighbourhood sum and reciprocal divide registers before
// m_tvalid rises.
// The line store is one RAM with a lane per row modulo three and two read ports, so each request
// that emits a result reads the current and the next column while the left column is held.
// Reset clears counters and the pipeline; the line store is not cleared.
// A full output register that is not taken stalls the whole pipeline and s_tready.
module box_blur_3x3_stream_unit
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [PIX_W-1:0]      s_tdata,   // [7:0] in_blue, [15:8] in_green, [23:16] in_red
    input  wire logic                  s_tuser,   // [0] cmd
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [PIX_W-1:0]      m_tdata,   // [7:0] out_blue, [15:8] out_green, [23:16] out_red
    output logic                       m_tlast,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [0:0]            cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WID_W = $clog2(MAX_WIDTH + 1);

    // Configuration and frame position registers.
    logic [FW_W-1:0]   frame_width_reg,  frame_width_next;
    logic [ROW_W-1:0]  frame_height_reg, frame_height_next;
    logic [ROW_W-1:0]  in_row_reg,  in_row_next;
    logic [COL_W-1:0]  in_col_reg,  in_col_next;
    logic [LANE_W-1:0] in_lane_reg, in_lane_next;
    logic [ROW_W-1:0]  out_row_reg,  out_row_next;
    logic [COL_W-1:0]  out_col_reg,  out_col_next;
    logic [LANE_W-1:0] out_lane_reg, out_lane_next;
    logic              frame_complete_reg, frame_complete_next;

    // Pipeline registers.
    logic                          s1_valid_reg;
    s1_ctrl_t                      s1_ctrl_reg;
    logic [LANES-1:0][PIX_W-1:0]   prev_col_reg;
    logic                          s2_valid_reg;
    logic [NCH-1:0][SUM_W-1:0]     s2_sum_reg;
    logic [CNT_W-1:0]              s2_n_reg;
    logic                          s2_last_reg;
    logic                          out_valid_reg;
    logic [PIX_W-1:0]              out_data_reg;
    logic                          out_last_reg;

    // Issue stage signals.
    logic              stall, adv, accept, have, emit, cfg_we;
    logic [WID_W-1:0]  w_eff, w_m1, ocp1, cc;
    logic [ROW_W-1:0]  h_eff, h_m1;
    logic [ROW_W:0]    orp1, rr;
    logic              in_col_last, in_row_last, out_col_last, out_row_last;
    logic [ROW_W-1:0]  nr;
    logic [COL_W-1:0]  nc;
    logic              complete_after, ready;
    s1_ctrl_t          s0_ctrl;
    logic [LANES-1:0]  lane_we;
    logic [COL_W-1:0]  raddr_b;
    logic [LANES*PIX_W-1:0] rdata_a, rdata_b;

    // Sum stage signals.
    logic [LANES-1:0][PIX_W-1:0] col_c, col_r;
    logic [NCH-1:0][SUM_W-1:0]   sum;
    logic [CNT_W-1:0]            cnt;

    // Divide stage signals.
    logic [PIX_W-1:0] quot;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign stall     = out_valid_reg && !m_tready;
    assign adv       = !stall;
    assign s_tready  = adv;
    assign accept    = s_tvalid && s_tready;

    // Effective frame size with clamping.
    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            w_eff = WID_W'(1);
        end
        else if (32'(frame_width_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = WID_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WID_W'(frame_width_reg);
        end
        h_eff = (frame_height_reg == '0) ? ROW_W'(1) : frame_height_reg;
        w_m1  = w_eff - WID_W'(1);
        h_m1  = h_eff - ROW_W'(1);
    end

    // Decide whether the oldest pending output can be produced by this request.
    always_comb
    begin
        have         = accept && (s_tuser == CMD_PIXEL) && !frame_complete_reg;
        in_col_last  = WID_W'(in_col_reg) == w_m1;
        in_row_last  = in_row_reg == h_m1;
        out_col_last = WID_W'(out_col_reg) == w_m1;
        out_row_last = out_row_reg == h_m1;
        nr = in_row_reg;
        nc = in_col_reg;
        if (have)
        begin
            if (in_col_last)
            begin
                nc = '0;
                nr = in_row_reg + ROW_W'(1);
            end
            else
            begin
                nc = in_col_reg + COL_W'(1);
            end
        end
        complete_after = frame_complete_reg || (have && in_row_last && in_col_last);
        orp1  = {1'b0, out_row_reg} + (ROW_W+1)'(1);
        rr    = (orp1 < {1'b0, h_eff}) ? orp1 : {1'b0, h_m1};
        ocp1  = WID_W'(out_col_reg) + WID_W'(1);
        cc    = (ocp1 < w_eff) ? ocp1 : w_m1;
        ready = complete_after || ({1'b0, nr} > rr) ||
                (({1'b0, nr} == rr) && (WID_W'(nc) > cc));
        emit  = accept && ready;
    end

    // Control for the sum stage.
    always_comb
    begin
        s0_ctrl.top_ok   = out_row_reg != '0;
        s0_ctrl.bot_ok   = !out_row_last;
        s0_ctrl.left_ok  = out_col_reg != '0;
        s0_ctrl.right_ok = !out_col_last;
        s0_ctrl.lane_mid = out_lane_reg;
        s0_ctrl.lane_top = lane_prev(out_lane_reg);
        s0_ctrl.lane_bot = lane_next(out_lane_reg);
        s0_ctrl.last     = out_row_last && out_col_last;
        s0_ctrl.fwd_a    = have && (in_col_reg == out_col_reg);
        s0_ctrl.fwd_b    = have && !out_col_last && (WID_W'(in_col_reg) == ocp1);
        s0_ctrl.fwd_lane = in_lane_reg;
        s0_ctrl.pix      = s_tdata;
        for (int l = 0; l < LANES; l++)
        begin
            lane_we[l] = in_lane_reg == LANE_W'(l);
        end
        raddr_b = out_col_last ? out_col_reg : COL_W'(ocp1);
    end

    bb3_ram #(
        .WIDTH (PIX_W),
        .LANES (LANES),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .we      (have),
        .lane_we (lane_we),
        .waddr   (in_col_reg),
        .wdata   ({LANES{s_tdata}}),
        .re_a    (emit),
        .raddr_a (out_col_reg),
        .rdata_a (rdata_a),
        .re_b    (emit),
        .raddr_b (raddr_b),
        .rdata_b (rdata_b)
    );

    // Next frame position and configuration.
    always_comb
    begin
        frame_width_next    = frame_width_reg;
        frame_height_next   = frame_height_reg;
        in_row_next         = in_row_reg;
        in_col_next         = in_col_reg;
        in_lane_next        = in_lane_reg;
        out_row_next        = out_row_reg;
        out_col_next        = out_col_reg;
        out_lane_next       = out_lane_reg;
        frame_complete_next = frame_complete_reg;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  frame_width_next  = cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: frame_height_next = cfg_data;
                default:          frame_width_next  = frame_width_reg;
            endcase
            in_row_next         = '0;
            in_col_next         = '0;
            in_lane_next        = '0;
            out_row_next        = '0;
            out_col_next        = '0;
            out_lane_next       = '0;
            frame_complete_next = 1'b0;
        end
        else
        begin
            if (have)
            begin
                in_row_next = nr;
                in_col_next = nc;
                if (in_col_last)
                begin
                    in_lane_next = lane_next(in_lane_reg);
                end
                if (complete_after)
                begin
                    frame_complete_next = 1'b1;
                end
            end
            if (emit)
            begin
                if (s0_ctrl.last)
                begin
                    in_row_next         = '0;
                    in_col_next         = '0;
                    in_lane_next        = '0;
                    out_row_next        = '0;
                    out_col_next        = '0;
                    out_lane_next       = '0;
                    frame_complete_next = 1'b0;
                end
                else if (out_col_last)
                begin
                    out_col_next  = '0;
                    out_row_next  = out_row_reg + ROW_W'(1);
                    out_lane_next = lane_next(out_lane_reg);
                end
                else
                begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg    <= FW_W'(1);
            frame_height_reg   <= ROW_W'(1);
            in_row_reg         <= '0;
            in_col_reg         <= '0;
            in_lane_reg        <= '0;
            out_row_reg        <= '0;
            out_col_reg        <= '0;
            out_lane_reg       <= '0;
            frame_complete_reg <= 1'b0;
        end
        else
        begin
            frame_width_reg    <= frame_width_next;
            frame_height_reg   <= frame_height_next;
            in_row_reg         <= in_row_next;
            in_col_reg         <= in_col_next;
            in_lane_reg        <= in_lane_next;
            out_row_reg        <= out_row_next;
            out_col_reg        <= out_col_next;
            out_lane_reg       <= out_lane_next;
            frame_complete_reg <= frame_complete_next;
        end
    end

    // Sum stage: forward the pixel written alongside the read, then add the window.
    always_comb
    begin
        logic [LANE_W-1:0] sel [3];
        logic              row_ok [3];
        logic              col_ok [3];
        logic [PIX_W-1:0]  v;
        sel[0]    = s1_ctrl_reg.lane_top;
        sel[1]    = s1_ctrl_reg.lane_mid;
        sel[2]    = s1_ctrl_reg.lane_bot;
        row_ok[0] = s1_ctrl_reg.top_ok;
        row_ok[1] = 1'b1;
        row_ok[2] = s1_ctrl_reg.bot_ok;
        col_ok[0] = s1_ctrl_reg.left_ok;
        col_ok[1] = 1'b1;
        col_ok[2] = s1_ctrl_reg.right_ok;
        for (int l = 0; l < LANES; l++)
        begin
            col_c[l] = (s1_ctrl_reg.fwd_a && s1_ctrl_reg.fwd_lane == LANE_W'(l)) ?
                       s1_ctrl_reg.pix : rdata_a[l*PIX_W +: PIX_W];
            col_r[l] = (s1_ctrl_reg.fwd_b && s1_ctrl_reg.fwd_lane == LANE_W'(l)) ?
                       s1_ctrl_reg.pix : rdata_b[l*PIX_W +: PIX_W];
        end
        sum = '0;
        cnt = '0;
        for (int j = 0; j < 3; j++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                case (j)
                    0:       v = prev_col_reg[sel[k]];
                    1:       v = col_c[sel[k]];
                    default: v = col_r[sel[k]];
                endcase
                if (row_ok[k] && col_ok[j])
                begin
                    cnt = cnt + CNT_W'(1);
                    for (int ch = 0; ch < NCH; ch++)
                    begin
                        sum[ch] = sum[ch] + SUM_W'(v[ch*CH_W +: CH_W]);
                    end
                end
            end
        end
    end

    // Divide stage: (2*sum + n) / (2n) by a reciprocal multiply.
    always_comb
    begin
        logic [X_W-1:0]    x;
        logic [PROD_W-1:0] prod;
        for (int ch = 0; ch < NCH; ch++)
        begin
            x    = {s2_sum_reg[ch], 1'b0} + X_W'(s2_n_reg);
            prod = PROD_W'(x) * PROD_W'(recip(s2_n_reg));
            quot[ch*CH_W +: CH_W] = prod[RECIP_SH +: CH_W];
        end
    end

    // Pipeline valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= emit;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (emit)
            begin
                s1_ctrl_reg <= s0_ctrl;
            end
            if (s1_valid_reg)
            begin
                prev_col_reg <= col_c;
                s2_sum_reg   <= sum;
                s2_n_reg     <= cnt;
                s2_last_reg  <= s1_ctrl_reg.last;
            end
            if (s2_valid_reg)
            begin
                out_data_reg <= quot;
                out_last_reg <= s2_last_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // The row lanes only take the values zero to two.
    a_lanes_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (in_lane_reg != 2'd3) && (out_lane_reg != 2'd3))
        else $error("row lane out of range");

    // The input column stays inside the frame.
    a_in_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        WID_W'(in_col_reg) < w_eff)
        else $error("input column beyond frame width");

    // Every request in the sum stage covers at least one neighbour.
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (cnt != '0))
        else $error("empty neighbourhood");

endmodule

`default_nettype wire

>>> hw/rtl/bb3_ram.sv
`default_nettype none

module bb3_ram #(
    parameter int WIDTH = 24,
    parameter int LANES = 3,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                         clk,
    input  wire logic                         we,
    input  wire logic [LANES-1:0]             lane_we,
    input  wire logic [AW-1:0]                waddr,
    input  wire logic [LANES*WIDTH-1:0]       wdata,
    input  wire logic                         re_a,
    input  wire logic [AW-1:0]                raddr_a,
    output logic      [LANES*WIDTH-1:0]       rdata_a,
    input  wire logic                         re_b,
    input  wire logic [AW-1:0]                raddr_b,
    output logic      [LANES*WIDTH-1:0]       rdata_b
);

    logic [LANES*WIDTH-1:0] mem [DEPTH];

    // Lane-masked write and two registered read ports.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                if (lane_we[l])
                begin
                    mem[waddr][l*WIDTH +: WIDTH] <= wdata[l*WIDTH +: WIDTH];
                end
            end
        end
        if (re_a)
        begin
            rdata_a <= mem[raddr_a];
        end
        if (re_b)
        begin
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

>>> bench/box_blur_3x3_stream_unit_tb.sv
`default_nettype none

module box_blur_3x3_stream_unit_tb;
    import bb3_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_W   = 1024;
    localparam int WDOG_MAX  = 3000;
    localparam int HOLD_LEN  = 250;

    typedef struct packed {
        logic             cmd;
        logic [PIX_W-1:0] pix;
    } px_req_t;

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
        logic            last;
    } blur_px_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [PIX_W-1:0]      m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [0:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Requests waiting for the driver and blurred pixels still owed by the block.
    px_req_t  px_fifo[$];
    blur_px_t blur_expect[$];

    // Mirror of the block's state.
    logic [PIX_W-1:0] mir_store[3*STORE_W];
    int unsigned      mir_width;
    int unsigned      mir_height;
    int unsigned      mir_in_row;
    int unsigned      mir_in_col;
    int unsigned      mir_out_row;
    int unsigned      mir_out_col;
    bit               mir_complete;

    int  n_errors;
    int  burst_left;
    int  gap_left;
    int  idle_cycles;
    int  ready_mode;
    int  mode_cycles;
    int  hold_count;
    bit  hold_req;

    box_blur_3x3_stream_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock and the single reset at the start.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic void clear_positions();
        mir_in_row   = 0;
        mir_in_col   = 0;
        mir_out_row  = 0;
        mir_out_col  = 0;
        mir_complete = 1'b0;
    endfunction

    // Work out what one request produces and queue it for the driver.
    task automatic send_request(input logic cmd, input logic [PIX_W-1:0] pix);
        int unsigned w, h, nr, nc, rr, cc, r, c, n;
        int unsigned sum_b, sum_g, sum_r;
        int          dr, dc;
        bit          have, done_after, ready;
        logic [PIX_W-1:0] v;
        blur_px_t    res;
        px_req_t     req;

        w = (mir_width == 0) ? 1 : ((mir_width > STORE_W) ? STORE_W : mir_width);
        h = (mir_height == 0) ? 1 : mir_height;
        have = (cmd == CMD_PIXEL) && !mir_complete;
        nr = mir_in_row;
        nc = mir_in_col;
        if (have)
        begin
            nc = mir_in_col + 1;
            if (nc >= w)
            begin
                nc = 0;
                nr = mir_in_row + 1;
            end
        end
        done_after = mir_complete ||
                     (have && mir_in_row == h - 1 && mir_in_col == w - 1);
        if (done_after)
            ready = 1'b1;
        else
        begin
            rr = (mir_out_row + 1 < h) ? mir_out_row + 1 : h - 1;
            cc = (mir_out_col + 1 < w) ? mir_out_col + 1 : w - 1;
            ready = (nr > rr) || (nr == rr && nc > cc);
        end

        // Sum the in-frame neighbours; the arriving pixel bypasses the store.
        sum_b = 0;
        sum_g = 0;
        sum_r = 0;
        n = 0;
        if (ready)
        begin
            for (dr = -1; dr <= 1; dr++)
            begin
                if (dr < 0 && mir_out_row == 0)
                    continue;
                r = mir_out_row + dr;
                if (r >= h)
                    continue;
                for (dc = -1; dc <= 1; dc++)
                begin
                    if (dc < 0 && mir_out_col == 0)
                        continue;
                    c = mir_out_col + dc;
                    if (c >= w)
                        continue;
                    if (have && r == mir_in_row && c == mir_in_col)
                        v = pix;
                    else
                        v = mir_store[(r % 3) * STORE_W + c];
                    sum_b += v[7:0];
                    sum_g += v[15:8];
                    sum_r += v[23:16];
                    n++;
                end
            end
        end

        if (have)
        begin
            mir_store[(mir_in_row % 3) * STORE_W + mir_in_col] = pix;
            mir_in_row = nr;
            mir_in_col = nc;
            if (done_after)
                mir_complete = 1'b1;
        end

        if (ready && n != 0)
        begin
            res.blue  = CH_W'((2 * sum_b + n) / (2 * n));
            res.green = CH_W'((2 * sum_g + n) / (2 * n));
            res.red   = CH_W'((2 * sum_r + n) / (2 * n));
            if (mir_out_row == h - 1 && mir_out_col == w - 1)
            begin
                res.last = 1'b1;
                clear_positions();
            end
            else
            begin
                res.last = 1'b0;
                mir_out_col++;
                if (mir_out_col >= w)
                begin
                    mir_out_col = 0;
                    mir_out_row++;
                end
            end
            blur_expect.push_back(res);
        end

        req.cmd = cmd;
        req.pix = pix;
        px_fifo.push_back(req);
    endtask

    function automatic logic [CH_W-1:0] rand_channel();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return CH_W'($urandom);
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        return {rand_channel(), rand_channel(), rand_channel()};
    endfunction

    // Wait until the block has nothing in flight, then write a register.
    task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
        while (px_fifo.size() != 0 || s_tvalid || blur_expect.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_FRAME_WIDTH)
            mir_width = value & 32'h7FF;
        else
            mir_height = value & 32'hFFFF;
        clear_positions();
    endtask

    task automatic set_frame(input int unsigned w, input int unsigned h);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
    endtask

    // One whole frame with drains mixed in, then flushed by drains and stray pixels.
    task automatic run_frame(input int drain_pct);
        int unsigned w, h, k;

        w = (mir_width == 0) ? 1 : ((mir_width > STORE_W) ? STORE_W : mir_width);
        h = (mir_height == 0) ? 1 : mir_height;
        for (k = 0; k < w * h; k++)
        begin
            if ($urandom_range(0, 99) < drain_pct)
                send_request(CMD_DRAIN, rand_pixel());
            send_request(CMD_PIXEL, rand_pixel());
        end
        while (mir_complete)
            send_request($urandom_range(0, 2) == 0 ? CMD_PIXEL : CMD_DRAIN, rand_pixel());
    endtask

    // Stimulus and phase control.
    initial
    begin
        int total;
        int nf;

        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = CMD_PIXEL;
        cfg_valid = 1'b0;
        cfg_index = REG_FRAME_WIDTH;
        cfg_data  = '0;
        hold_req  = 1'b0;
        n_errors  = 0;
        mir_width  = 1;
        mir_height = 1;
        clear_positions();

        @(posedge rst_n);
        @(posedge clk);

        // Reset geometry of one pixel: a drain, then two pixels that each make a whole frame.
        send_request(CMD_DRAIN, 24'h000000);
        send_request(CMD_PIXEL, 24'hFFFFFF);
        send_request(CMD_PIXEL, 24'h123456);

        // A 3x3 frame of extreme values, drained early and after the end.
        set_frame(3, 3);
        send_request(CMD_PIXEL, 24'hFFFFFF);
        send_request(CMD_PIXEL, 24'h000000);
        send_request(CMD_PIXEL, 24'hFF00FF);
        send_request(CMD_DRAIN, 24'hFFFFFF);
        send_request(CMD_PIXEL, 24'h00FF00);
        send_request(CMD_PIXEL, 24'hFFFFFF);
        send_request(CMD_PIXEL, 24'h010101);
        send_request(CMD_PIXEL, 24'hFEFEFE);
        send_request(CMD_PIXEL, 24'h000000);
        send_request(CMD_PIXEL, 24'hFFFFFF);
        send_request(CMD_PIXEL, 24'hAAAAAA);
        while (mir_complete)
            send_request(CMD_DRAIN, 24'h000000);

        // Zero width and zero height both act as one.
        set_frame(0, 0);
        run_frame(0);
        set_frame(2, 0);
        run_frame(20);

        // Oversized width is clipped to the widest line.
        set_frame(2047, 1);
        run_frame(5);

        // Tallest frame, abandoned part way through by the next register write.
        set_frame(2, 65535);
        for (int k = 0; k < 40; k++)
            send_request(CMD_PIXEL, rand_pixel());
        repeat (4) send_request(CMD_DRAIN, rand_pixel());

        // Output held off for a long stretch while the input keeps coming.
        set_frame(30, 4);
        hold_req = 1'b1;
        run_frame(3);

        // Random geometries, mostly small, a few wide.
        total = 0;
        while (total < 80)
        begin
            if ($urandom_range(0, 9) == 0)
                set_frame($urandom_range(13, 60), $urandom_range(1, 4));
            else
                set_frame($urandom_range(1, 12), $urandom_range(1, 8));
            nf = $urandom_range(1, 3);
            repeat (nf)
            begin
                run_frame($urandom_range(0, 15));
                total += int'(mir_width * mir_height);
            end
        end

        while (px_fifo.size() != 0 || s_tvalid || blur_expect.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Sender: bursts of random length separated by random gaps.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            burst_left <= 0;
            gap_left   <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (gap_left > 0)
            begin
                s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (px_fifo.size() != 0)
            begin
                s_tvalid <= 1'b1;
                s_tuser  <= px_fifo[0].cmd;
                s_tdata  <= px_fifo[0].pix;
                void'(px_fifo.pop_front());
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: a stall pattern that changes mode, plus one long hold when asked.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready    <= 1'b0;
            ready_mode  <= 0;
            mode_cycles <= 0;
            hold_count  <= 0;
        end
        else if (hold_req && hold_count < HOLD_LEN)
        begin
            m_tready   <= 1'b0;
            hold_count <= hold_count + 1;
        end
        else
        begin
            if (mode_cycles == 0)
            begin
                ready_mode  <= $urandom_range(0, 3);
                mode_cycles <= $urandom_range(20, 120);
            end
            else
                mode_cycles <= mode_cycles - 1;
            case (ready_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= $urandom_range(0, 1);
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Checker: each accepted output against the oldest expected pixel.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (blur_expect.size() == 0)
            begin
                $error("unexpected output pixel %h last %b", m_tdata, m_tlast);
                n_errors++;
            end
            else
            begin
                if (m_tdata[7:0] !== blur_expect[0].blue)
                begin
                    $error("out_blue expected %0d actual %0d",
                           blur_expect[0].blue, m_tdata[7:0]);
                    n_errors++;
                end
                if (m_tdata[15:8] !== blur_expect[0].green)
                begin
                    $error("out_green expected %0d actual %0d",
                           blur_expect[0].green, m_tdata[15:8]);
                    n_errors++;
                end
                if (m_tdata[23:16] !== blur_expect[0].red)
                begin
                    $error("out_red expected %0d actual %0d",
                           blur_expect[0].red, m_tdata[23:16]);
                    n_errors++;
                end
                if (m_tlast !== blur_expect[0].last)
                begin
                    $error("frame_end expected %0d actual %0d",
                           blur_expect[0].last, m_tlast);
                    n_errors++;
                end
                void'(blur_expect.pop_front());
            end
        end
    end

    // Watchdog on cycles in which no request moves on any channel.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WDOG_MAX)
        begin
            $display("status: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

`default_nettype wire
